// ----- design/bpa_pkg.sv -----
package bpa_pkg;

  localparam int unsigned NUM_PAGES_DEF  = 512;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  // width of the candidate window looked at per scan cycle
  localparam int unsigned SCAN_W  = 64;
  // wide enough for a page range bound at the largest map size
  localparam int unsigned RANGE_W = 13;

  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned FIRST_W  = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ADDR_W   = 64;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_NO_RUN = 2'd1,
    STATUS_ZERO   = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_RUN,
    CELL_SCAN,
    CELL_SET,
    CELL_CLEAR
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_e;

  typedef struct packed {
    cell_op_e             op;
    logic [RANGE_W-1:0]   lo;
    logic [RANGE_W-1:0]   hi;
  } cell_ctl_t;

endpackage

// ----- design/bitmap_page_allocator.sv -----
// free, zero count or oversized count: idle goes to done, then the result loads the output register
// allocate of N pages: the run phase shifts the map through the cell row, then
// window scans look for the lowest candidate, a mark state sets the run, then done loads the output register
// once it is free; no free run ends the scan at the last window and goes straight to done; a new transaction
// is only taken in idle, so not before the last one is through, but it is taken while the last result waits
// reset: async active low, every page free, region base zero, no result pending
module bitmap_page_allocator #(
  parameter int unsigned NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_wr_en_i,
  input  logic [bpa_pkg::ADDR_W-1:0]   cfg_wr_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [bpa_pkg::COUNT_W-1:0]  page_count_i,
  input  logic [bpa_pkg::INDEX_W-1:0]  page_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bpa_pkg::STATUS_W-1:0] status_o,
  output logic [bpa_pkg::FIRST_W-1:0]  first_page_o,
  output logic [bpa_pkg::ADDR_W-1:0]   page_address_o
);

  localparam int unsigned SW  = (NUM_PAGES < bpa_pkg::SCAN_W) ? NUM_PAGES : bpa_pkg::SCAN_W;
  localparam int unsigned SIW = $clog2(SW);
  localparam int unsigned PW  = $clog2(NUM_PAGES);
  localparam int unsigned CW  = $clog2(NUM_PAGES + 1);
  localparam int unsigned BW  = (CW > bpa_pkg::COUNT_W) ? CW : bpa_pkg::COUNT_W;
  localparam int unsigned XW  = (PW > bpa_pkg::FIRST_W) ? PW : bpa_pkg::FIRST_W;

  bpa_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    k_q, k_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    wbase_q, wbase_d;
  logic [PW-1:0]    start_q, start_d;

  bpa_pkg::status_e              res_status_q, res_status_d;
  logic [bpa_pkg::FIRST_W-1:0]   res_first_q, res_first_d;
  logic [bpa_pkg::ADDR_W-1:0]    res_addr_q, res_addr_d;

  logic                          out_valid_q;
  bpa_pkg::status_e              out_status_q;
  logic [bpa_pkg::FIRST_W-1:0]   out_first_q;
  logic [bpa_pkg::ADDR_W-1:0]    out_addr_q;
  logic [bpa_pkg::ADDR_W-1:0]    base_q;

  bpa_pkg::cell_ctl_t  ctl;
  logic [NUM_PAGES-1:0] s_vec;
  logic [NUM_PAGES-1:0] c_vec;
  logic                 win_any;
  logic [SIW-1:0]       win_idx;

  logic          in_acc;
  logic          out_load;
  logic          is_free;
  logic          too_big;
  logic          last_word;
  logic [CW-1:0] found_page;
  logic [XW-1:0] start_x;

  assign in_ready_o = (state_q == bpa_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == bpa_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
  assign is_free    = (bpa_pkg::func_e'(func_i) == bpa_pkg::FUNC_FREE);
  assign too_big    = BW'(page_count_i) > BW'(NUM_PAGES);
  assign last_word  = ({1'b0, wbase_q} + (CW + 1)'(SW)) >= (CW + 1)'(NUM_PAGES);
  assign found_page = wbase_q + CW'(win_idx);
  assign start_x    = XW'(start_q);

  // row of page cells
  for (genvar p = 0; p < NUM_PAGES; p++) begin : g_cell
    logic s_up;
    logic c_far;
    if (p + 1 < NUM_PAGES) begin : g_s_in
      assign s_up = s_vec[p+1];
    end else begin : g_s_end
      assign s_up = 1'b0;
    end
    if (p + SW < NUM_PAGES) begin : g_c_in
      assign c_far = c_vec[p+SW];
    end else begin : g_c_end
      assign c_far = 1'b0;
    end
    bpa_cell #(
      .INDEX(p)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .s_up_i  (s_up),
      .c_far_i (c_far),
      .s_o     (s_vec[p]),
      .c_o     (c_vec[p])
    );
  end

  bpa_lowest #(
    .WIDTH(SW)
  ) u_lowest (
    .vec_i (c_vec[SW-1:0]),
    .any_o (win_any),
    .idx_o (win_idx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_free || (page_count_i == '0) || too_big) begin
            state_d = bpa_pkg::ST_DONE;
          end else begin
            state_d = bpa_pkg::ST_RUN;
          end
        end
      end
      bpa_pkg::ST_RUN: begin
        if (k_q == CW'(1)) begin
          state_d = bpa_pkg::ST_SCAN;
        end
      end
      bpa_pkg::ST_SCAN: begin
        if (win_any) begin
          state_d = bpa_pkg::ST_MARK;
        end else if (last_word) begin
          state_d = bpa_pkg::ST_DONE;
        end
      end
      bpa_pkg::ST_MARK: begin
        state_d = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  // cell control and datapath
  always_comb begin
    ctl.op       = bpa_pkg::CELL_HOLD;
    ctl.lo       = '0;
    ctl.hi       = '0;
    k_d          = k_q;
    cnt_d        = cnt_q;
    wbase_d      = wbase_q;
    start_d      = start_q;
    res_status_d = res_status_q;
    res_first_d  = res_first_q;
    res_addr_d   = res_addr_q;
    unique case (state_q)
      bpa_pkg::ST_IDLE: begin
        res_first_d = '0;
        res_addr_d  = '0;
        if (in_acc) begin
          if (is_free) begin
            // an index past the map matches no cell
            ctl.op       = bpa_pkg::CELL_CLEAR;
            ctl.lo       = bpa_pkg::RANGE_W'(page_index_i);
            ctl.hi       = bpa_pkg::RANGE_W'(page_index_i) + bpa_pkg::RANGE_W'(1);
            res_status_d = bpa_pkg::STATUS_DONE;
          end else if (page_count_i == '0) begin
            res_status_d = bpa_pkg::STATUS_ZERO;
          end else if (too_big) begin
            res_status_d = bpa_pkg::STATUS_NO_RUN;
          end else begin
            ctl.op = bpa_pkg::CELL_LOAD;
            k_d    = CW'(page_count_i);
            cnt_d  = CW'(page_count_i);
          end
        end
      end
      bpa_pkg::ST_RUN: begin
        ctl.op  = bpa_pkg::CELL_RUN;
        k_d     = k_q - CW'(1);
        wbase_d = '0;
      end
      bpa_pkg::ST_SCAN: begin
        if (win_any) begin
          start_d = found_page[PW-1:0];
        end else begin
          ctl.op  = bpa_pkg::CELL_SCAN;
          wbase_d = wbase_q + CW'(SW);
          if (last_word) begin
            res_status_d = bpa_pkg::STATUS_NO_RUN;
          end
        end
      end
      bpa_pkg::ST_MARK: begin
        ctl.op       = bpa_pkg::CELL_SET;
        ctl.lo       = bpa_pkg::RANGE_W'(start_q);
        ctl.hi       = bpa_pkg::RANGE_W'(start_q) + bpa_pkg::RANGE_W'(cnt_q);
        res_status_d = bpa_pkg::STATUS_DONE;
        res_first_d  = start_x[bpa_pkg::FIRST_W-1:0];
        res_addr_d   = base_q + (bpa_pkg::ADDR_W'(start_q) << PAGE_SHIFT);
      end
      bpa_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr_en_i) begin
        base_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    cnt_q        <= cnt_d;
    wbase_q      <= wbase_d;
    start_q      <= start_d;
    res_status_q <= res_status_d;
    res_first_q  <= res_first_d;
    res_addr_q   <= res_addr_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign first_page_o   = out_first_q;
  assign page_address_o = out_addr_q;

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpa_pkg::ST_RUN |-> k_q != '0)
    else $error("run counter reached zero inside the run phase");

  a_scan_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpa_pkg::ST_SCAN |-> wbase_q < CW'(NUM_PAGES))
    else $error("scan window past the end of the map");

  a_mark_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpa_pkg::ST_MARK |->
      ((bpa_pkg::RANGE_W + 1)'(start_q) + (bpa_pkg::RANGE_W + 1)'(cnt_q))
        <= (bpa_pkg::RANGE_W + 1)'(NUM_PAGES))
    else $error("granted run extends past the map");

  a_fail_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bpa_pkg::STATUS_DONE) |->
      (page_address_o == '0) && (first_page_o == '0))
    else $error("failed transaction carries a page or address");

endmodule

// ----- design/bpa_cell.sv -----
module bpa_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpa_pkg::cell_ctl_t  ctl_i,
  input  logic                s_up_i,
  input  logic                c_far_i,
  output logic                s_o,
  output logic                c_o
);

  localparam logic [bpa_pkg::RANGE_W-1:0] MyIdx = bpa_pkg::RANGE_W'(INDEX);

  logic used_q, used_d;
  logic s_q, s_d;
  logic c_q, c_d;
  logic in_range;

  assign in_range = (MyIdx >= ctl_i.lo) && (MyIdx < ctl_i.hi);

  always_comb begin
    used_d = used_q;
    s_d    = s_q;
    c_d    = c_q;
    unique case (ctl_i.op)
      bpa_pkg::CELL_HOLD: begin
      end
      bpa_pkg::CELL_LOAD: begin
        s_d = ~used_q;
        c_d = 1'b1;
      end
      // candidate keeps its bit only while every page shifted past it is free
      bpa_pkg::CELL_RUN: begin
        c_d = c_q & s_q;
        s_d = s_up_i;
      end
      bpa_pkg::CELL_SCAN: begin
        c_d = c_far_i;
      end
      bpa_pkg::CELL_SET: begin
        used_d = used_q | in_range;
      end
      bpa_pkg::CELL_CLEAR: begin
        used_d = used_q & ~in_range;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    c_q <= c_d;
  end

  assign s_o = s_q;
  assign c_o = c_q;

endmodule

// ----- design/bpa_lowest.sv -----
module bpa_lowest #(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH-1:0]         vec_i,
  output logic                     any_o,
  output logic [$clog2(WIDTH)-1:0] idx_o
);

  localparam int unsigned IdxW = $clog2(WIDTH);

  logic [WIDTH-1:0] low;

  // isolate the lowest set bit, then encode the one-hot
  assign low   = vec_i & (~vec_i + WIDTH'(1));
  assign any_o = |vec_i;

  always_comb begin
    idx_o = '0;
    for (int b = 0; b < IdxW; b++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (((i >> b) & 1) == 1) begin
          idx_o[b] = idx_o[b] | low[i];
        end
      end
    end
  end

endmodule
